>>> rtl/slr_pkg.sv
// ----------------------------------------------------------------------------
// slr_pkg
// Shared types, constants and helpers for the status line receiver.
// ----------------------------------------------------------------------------
package slr_pkg;

  // Default line buffer size in bytes (legal range 10 to 255)
  localparam int unsigned LINE_BUFFER_SIZE_DEF = 32;

  // Configuration port
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [7:0]  BAND_LIMIT_RST = 8'd10;

  // Register indexes
  typedef enum logic {
    REG_BAND_LIMIT = 1'b0,
    REG_UNUSED     = 1'b1
  } cfg_reg_t;

  // Input item kinds
  typedef enum logic {
    KIND_BYTE    = 1'b0,
    KIND_TIMEOUT = 1'b1
  } item_kind_t;

  // Characters of interest
  localparam logic [7:0] CHR_NL   = 8'h0A;
  localparam logic [7:0] CHR_NUL  = 8'h00;
  localparam logic [7:0] CHR_DEV  = 8'h44; // 'D'
  localparam logic [7:0] CHR_PC   = 8'h50; // 'P'
  localparam logic [7:0] CHR_STAT = 8'h53; // 'S'

  // Text length is only compared against small values: saturate early
  localparam int unsigned TLEN_W = 4;
  localparam logic [TLEN_W-1:0] TLEN_SAT    = 4'd9;
  localparam logic [TLEN_W-1:0] TLEN_STATUS = 4'd8;
  localparam logic [TLEN_W-1:0] TLEN_MIN    = 4'd2;
  localparam logic [TLEN_W-1:0] TLEN_BAND_LAST = 4'd3;
  localparam logic [TLEN_W-1:0] TLEN_HEX_LAST  = 4'd7;

  // One result item
  typedef struct packed {
    logic        line_valid;
    logic        pc_mode;
    logic        status_accepted;
    logic        update_needed;
    logic [7:0]  peer_band;
    logic [15:0] peer_antenna;
  } slr_result_t;

  // Hex digit decode: {bad, value}; bad digits give value 0
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    begin
      r = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
        r = {1'b0, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
        r = {1'b0, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
        r = {1'b0, 4'(c - 8'h57)};
      end
      return r;
    end
  endfunction

endpackage

>>> rtl/slr_cfg.sv
// ----------------------------------------------------------------------------
// slr_cfg
// APB-style register file holding the band limit.
// ----------------------------------------------------------------------------
module slr_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [slr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [slr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [slr_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready,
  output logic [7:0]                    band_limit
);
  import slr_pkg::*;

  logic [7:0] band_limit_r;
  logic       wr_en;
  cfg_reg_t   reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_limit_r <= BAND_LIMIT_RST;
    end else if (wr_en && reg_sel == REG_BAND_LIMIT) begin
      band_limit_r <= pwdata[7:0];
    end
  end

  // read back
  always_comb begin
    case (reg_sel)
      REG_BAND_LIMIT: prdata = {{(CFG_DATA_W-8){1'b0}}, band_limit_r};
      default:        prdata = '0;
    endcase
  end

  assign band_limit = band_limit_r;

endmodule

>>> rtl/slr_line_proc.sv
// ----------------------------------------------------------------------------
// slr_line_proc
// Line framing state and classification of a finished line.
// ----------------------------------------------------------------------------
module slr_line_proc #(
  parameter int unsigned LINE_BUFFER_SIZE = slr_pkg::LINE_BUFFER_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_fire,
  input  logic                 item_kind,
  input  logic [7:0]           item_byte,
  input  logic [7:0]           band_limit,
  output logic                 has_result,
  output slr_pkg::slr_result_t res
);
  import slr_pkg::*;

  localparam int unsigned CNT_W = $clog2(LINE_BUFFER_SIZE + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LINE_BUFFER_SIZE);

  logic [CNT_W-1:0]  line_cnt_r, line_cnt_nxt, cnt_inc;
  logic [TLEN_W-1:0] tlen_r, tlen_nxt;
  logic              zero_seen_r, zero_seen_nxt;
  logic [7:0]        sender_r, sender_nxt;
  logic [7:0]        type_r, type_nxt;
  logic              hex_ok_r, hex_ok_nxt;
  logic [7:0]        band_acc_r, band_acc_nxt;
  logic [15:0]       ant_acc_r, ant_acc_nxt;
  logic [7:0]        st_band_r, st_band_nxt;
  logic [15:0]       st_ant_r, st_ant_nxt;
  logic              link_up_r, link_up_nxt;
  logic              pc_mode_r, pc_mode_nxt;

  logic              is_dev, is_pc, long_enough, valid, accepted, update;
  logic              mode_after;
  logic              cnt_full, is_byte;
  logic [4:0]        hex;

  assign is_byte  = (item_kind_t'(item_kind) == KIND_BYTE);
  assign cnt_full = (line_cnt_r >= CNT_FULL);
  assign cnt_inc  = line_cnt_r + 1'b1;
  assign hex      = hex_decode(item_byte);

  // classification of the line held so far
  assign long_enough = (tlen_r >= TLEN_MIN);
  assign is_dev      = long_enough && (sender_r == CHR_DEV);
  assign is_pc       = long_enough && (sender_r == CHR_PC);
  assign valid       = is_dev || is_pc;
  assign accepted    = is_dev && (type_r == CHR_STAT) && (tlen_r == TLEN_STATUS) &&
                       hex_ok_r && (band_acc_r <= band_limit);
  assign update      = accepted && ((band_acc_r != st_band_r) ||
                       (ant_acc_r != st_ant_r) || !link_up_r);
  assign mode_after  = is_dev ? 1'b0 : (is_pc ? 1'b1 : pc_mode_r);

  assign has_result  = is_byte && !cnt_full && (item_byte == CHR_NL);

  // result fields reflect the state after the line
  always_comb begin
    res.line_valid      = valid;
    res.pc_mode         = mode_after;
    res.status_accepted = accepted;
    res.update_needed   = update;
    res.peer_band       = accepted ? band_acc_r : st_band_r;
    res.peer_antenna    = accepted ? ant_acc_r  : st_ant_r;
  end

  // next state for one item
  always_comb begin
    line_cnt_nxt  = line_cnt_r;
    tlen_nxt      = tlen_r;
    zero_seen_nxt = zero_seen_r;
    sender_nxt    = sender_r;
    type_nxt      = type_r;
    hex_ok_nxt    = hex_ok_r;
    band_acc_nxt  = band_acc_r;
    ant_acc_nxt   = ant_acc_r;
    st_band_nxt   = st_band_r;
    st_ant_nxt    = st_ant_r;
    link_up_nxt   = link_up_r;
    pc_mode_nxt   = pc_mode_r;
    if (!is_byte) begin
      link_up_nxt = 1'b0;
    end else if (!cnt_full) begin
      line_cnt_nxt = cnt_inc;
      if (item_byte == CHR_NL) begin
        // finish line
        pc_mode_nxt = mode_after;
        if (valid) begin
          link_up_nxt = 1'b1;
        end
        if (accepted) begin
          st_band_nxt = band_acc_r;
          st_ant_nxt  = ant_acc_r;
        end
      end else begin
        if (!zero_seen_r) begin
          if (item_byte == CHR_NUL) begin
            zero_seen_nxt = 1'b1;
          end else begin
            // take a text character
            if (tlen_r == '0) begin
              sender_nxt = item_byte;
            end else if (tlen_r == TLEN_W'(1)) begin
              type_nxt = item_byte;
            end else if (tlen_r <= TLEN_HEX_LAST) begin
              if (hex[4]) begin
                hex_ok_nxt = 1'b0;
              end
              if (tlen_r <= TLEN_BAND_LAST) begin
                band_acc_nxt = {band_acc_r[3:0], hex[3:0]};
              end else begin
                ant_acc_nxt = {ant_acc_r[11:0], hex[3:0]};
              end
            end
            if (tlen_r < TLEN_SAT) begin
              tlen_nxt = tlen_r + 1'b1;
            end
          end
        end
      end
      // newline or overflow: start a fresh line
      if (item_byte == CHR_NL || cnt_inc == CNT_FULL) begin
        line_cnt_nxt  = '0;
        tlen_nxt      = '0;
        zero_seen_nxt = 1'b0;
        sender_nxt    = '0;
        type_nxt      = '0;
        hex_ok_nxt    = 1'b1;
        band_acc_nxt  = '0;
        ant_acc_nxt   = '0;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_cnt_r  <= '0;
      tlen_r      <= '0;
      zero_seen_r <= 1'b0;
      sender_r    <= '0;
      type_r      <= '0;
      hex_ok_r    <= 1'b1;
      band_acc_r  <= '0;
      ant_acc_r   <= '0;
      st_band_r   <= '0;
      st_ant_r    <= '0;
      link_up_r   <= 1'b0;
      pc_mode_r   <= 1'b0;
    end else if (item_fire) begin
      line_cnt_r  <= line_cnt_nxt;
      tlen_r      <= tlen_nxt;
      zero_seen_r <= zero_seen_nxt;
      sender_r    <= sender_nxt;
      type_r      <= type_nxt;
      hex_ok_r    <= hex_ok_nxt;
      band_acc_r  <= band_acc_nxt;
      ant_acc_r   <= ant_acc_nxt;
      st_band_r   <= st_band_nxt;
      st_ant_r    <= st_ant_nxt;
      link_up_r   <= link_up_nxt;
      pc_mode_r   <= pc_mode_nxt;
    end
  end

endmodule

>>> rtl/status_line_receiver_core.sv
// ----------------------------------------------------------------------------
// status_line_receiver_core
// Frames received bytes into lines and reports classified status lines.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+--------------------------------
//   in_      | input     | in_valid/in_stall  | kind, rx_byte
//   out_     | output    | out_valid/out_stall| line_valid .. peer_antenna
//   cfg_     | input     | APB write/read     | band_limit at address 0
//
// One item per cycle while no stalled result holds it back: an input register
// feeds the line state update and the classifier, whose result is registered
// in the output register.
// Reset is synchronous; all line state and the band limit reset at once.
// A stalled result blocks only items that produce a result; others pass.
// ----------------------------------------------------------------------------
module status_line_receiver_core #(
  parameter int unsigned LINE_BUFFER_SIZE = slr_pkg::LINE_BUFFER_SIZE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_kind,
  input  logic [7:0]                     in_rx_byte,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_line_valid,
  output logic                           out_pc_mode,
  output logic                           out_status_accepted,
  output logic                           out_update_needed,
  output logic [7:0]                     out_peer_band,
  output logic [15:0]                    out_peer_antenna,
  // configuration
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [slr_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [slr_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [slr_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import slr_pkg::*;

  logic        s1_valid_r;
  logic        s1_kind_r;
  logic [7:0]  s1_byte_r;
  logic        s1_fire, s1_has_res, in_take;
  logic        out_free;
  logic [7:0]  band_limit;
  slr_result_t s1_res;
  logic        out_valid_r;
  slr_result_t out_res_r;

  // configuration registers
  slr_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .prdata     (cfg_prdata),
    .pready     (cfg_pready),
    .band_limit (band_limit)
  );

  // stage advance: an item with a result needs room in the output register
  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && (!s1_has_res || out_free);
  assign in_stall = s1_valid_r && !s1_fire;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take || s1_fire) begin
      s1_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_kind_r <= in_kind;
      s1_byte_r <= in_rx_byte;
    end
  end

  // line state and classifier
  slr_line_proc #(
    .LINE_BUFFER_SIZE (LINE_BUFFER_SIZE)
  ) u_line (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_fire  (s1_fire),
    .item_kind  (s1_kind_r),
    .item_byte  (s1_byte_r),
    .band_limit (band_limit),
    .has_result (s1_has_res),
    .res        (s1_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_has_res) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_has_res) begin
      out_res_r <= s1_res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_line_valid      = out_res_r.line_valid;
  assign out_pc_mode         = out_res_r.pc_mode;
  assign out_status_accepted = out_res_r.status_accepted;
  assign out_update_needed   = out_res_r.update_needed;
  assign out_peer_band       = out_res_r.peer_band;
  assign out_peer_antenna    = out_res_r.peer_antenna;

  // checks
  a_update_implies_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_res_r.update_needed || out_res_r.status_accepted))
    else $error("update flagged without a stored status");

  a_accept_is_device: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.status_accepted) |->
      (out_res_r.line_valid && !out_res_r.pc_mode))
    else $error("status stored from a line that is not a device line");

  a_result_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_res_r)))
    else $error("stalled result changed or dropped");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with an empty input register");

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for status_line_receiver_core. It sends received bytes and
// link-timeout events, predicts each finished line's result with a
// cycle-free behavioural copy of the receiver, and compares every result
// field by field. Directed lines cover the framing and classification corner
// cases. Random traffic covers three idling mixes and several band limits.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import slr_pkg::*;

  localparam int unsigned BUF_SIZE   = LINE_BUFFER_SIZE_DEF;
  localparam int unsigned MAX_SHOWN  = 10;
  localparam int          CASE_UPPER = 0;
  localparam int          CASE_LOWER = 1;
  localparam int          CASE_MIXED = 2;

  // DUT connections
  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic                  in_kind     = 1'b0;
  logic [7:0]            in_rx_byte  = 8'h00;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic                  out_line_valid;
  logic                  out_pc_mode;
  logic                  out_status_accepted;
  logic                  out_update_needed;
  logic [7:0]            out_peer_band;
  logic [15:0]           out_peer_antenna;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  status_line_receiver_core #(
    .LINE_BUFFER_SIZE(BUF_SIZE)
  ) DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_line_valid      (out_line_valid),
    .out_pc_mode         (out_pc_mode),
    .out_status_accepted (out_status_accepted),
    .out_update_needed   (out_update_needed),
    .out_peer_band       (out_peer_band),
    .out_peer_antenna    (out_peer_antenna),
    .cfg_psel            (cfg_psel),
    .cfg_penable         (cfg_penable),
    .cfg_pwrite          (cfg_pwrite),
    .cfg_paddr           (cfg_paddr),
    .cfg_pwdata          (cfg_pwdata),
    .cfg_prdata          (cfg_prdata),
    .cfg_pready          (cfg_pready)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Shared state
  // --------------------------------------------------------------------------
  slr_result_t pending_lines[$];   // results still owed by the DUT
  logic [7:0]  line_buf[$];        // bytes of the line being assembled
  slr_result_t seen_line;
  slr_result_t want_line;
  logic        in_taken  = 1'b0;
  logic        out_taken = 1'b0;
  int          in_idle_pct  = 0;
  int          out_idle_pct = 0;
  int unsigned mismatches = 0;
  int unsigned n_items    = 0;
  int unsigned n_timeouts = 0;
  int unsigned n_lines    = 0;
  int unsigned n_stored   = 0;
  int unsigned n_updates  = 0;

  // Predictor state
  logic [7:0]  band_limit_m = BAND_LIMIT_RST;
  logic [7:0]  line_cnt_m   = '0;
  logic [7:0]  text_len_m   = '0;
  logic        zero_seen_m  = 1'b0;
  logic [7:0]  sender_m     = '0;
  logic [7:0]  type_m       = '0;
  logic        hex_ok_m     = 1'b1;
  logic [7:0]  band_acc_m   = '0;
  logic [15:0] ant_acc_m    = '0;
  logic [7:0]  stored_band_m = '0;
  logic [15:0] stored_ant_m  = '0;
  logic        link_up_m    = 1'b0;
  logic        pc_mode_m    = 1'b0;

  // --------------------------------------------------------------------------
  // Line predictor
  // --------------------------------------------------------------------------
  // {bad, nibble}; folding bit 5 maps upper-case hex letters onto lower case
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    logic [7:0] folded;
    folded = c | 8'h20;
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
    if (folded >= 8'h61 && folded <= 8'h66) return {1'b0, c[3:0] + 4'd9};
    return 5'b10000;
  endfunction

  task automatic restart_line();
    line_cnt_m  = '0;
    text_len_m  = '0;
    zero_seen_m = 1'b0;
    sender_m    = '0;
    type_m      = '0;
    hex_ok_m    = 1'b1;
    band_acc_m  = '0;
    ant_acc_m   = '0;
  endtask

  task automatic absorb_char(input logic [7:0] c);
    logic [4:0] d;
    if (text_len_m == 8'd0) begin
      sender_m = c;
    end else if (text_len_m == 8'd1) begin
      type_m = c;
    end else if (text_len_m <= 8'd7) begin
      d = digit_value(c);
      if (d[4]) begin
        hex_ok_m = 1'b0;
        d = 5'd0;
      end
      if (text_len_m <= 8'd3) band_acc_m = {band_acc_m[3:0], d[3:0]};
      else ant_acc_m = {ant_acc_m[11:0], d[3:0]};
    end
    if (text_len_m != 8'hFF) text_len_m++;
  endtask

  task automatic close_line();
    slr_result_t r;
    r = '0;
    if (text_len_m >= 8'd2) begin
      if (sender_m == CHR_DEV) begin
        r.line_valid = 1'b1;
        pc_mode_m = 1'b0;
        if (type_m == CHR_STAT && text_len_m == 8'd8 && hex_ok_m &&
            band_acc_m <= band_limit_m) begin
          r.status_accepted = 1'b1;
          r.update_needed = (band_acc_m != stored_band_m) ||
                            (ant_acc_m != stored_ant_m) || !link_up_m;
          stored_band_m = band_acc_m;
          stored_ant_m  = ant_acc_m;
        end
      end else if (sender_m == CHR_PC) begin
        r.line_valid = 1'b1;
        pc_mode_m = 1'b1;
      end
      if (r.line_valid) link_up_m = 1'b1;
    end
    r.pc_mode      = pc_mode_m;
    r.peer_band    = stored_band_m;
    r.peer_antenna = stored_ant_m;
    pending_lines.push_back(r);
  endtask

  task automatic predict_item(input item_kind_t k, input logic [7:0] c);
    if (k == KIND_TIMEOUT) begin
      link_up_m = 1'b0;
    end else if (line_cnt_m < BUF_SIZE) begin
      line_cnt_m++;
      if (c == CHR_NL) begin
        close_line();
        restart_line();
      end else begin
        if (!zero_seen_m) begin
          if (c == CHR_NUL) zero_seen_m = 1'b1;
          else absorb_char(c);
        end
        // line filled without a newline: dropped
        if (line_cnt_m >= BUF_SIZE) restart_line();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Handshake sampling, result stall and result checking
  // --------------------------------------------------------------------------
  // sampled mid-cycle so that the following rising edge sees settled values
  always @(negedge clk) begin
    in_taken  = rst_n && in_valid && (in_stall === 1'b0);
    out_taken = rst_n && (out_valid === 1'b1) && !out_stall;
    seen_line = {out_line_valid, out_pc_mode, out_status_accepted,
                 out_update_needed, out_peer_band, out_peer_antenna};
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  task automatic note_mismatch(input string what, input int unsigned want_v,
                               input int unsigned got_v);
    mismatches++;
    if (mismatches <= MAX_SHOWN)
      $display("%0t: %s mismatch, expected 'h%0h, got 'h%0h",
               $time, what, want_v, got_v);
  endtask

  always @(posedge clk) begin
    if (out_taken) begin
      if (pending_lines.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("%0t: result transaction with no line pending", $time);
      end else begin
        want_line = pending_lines.pop_front();
        n_lines++;
        if (want_line.status_accepted) n_stored++;
        if (want_line.update_needed) n_updates++;
        if (seen_line.line_valid !== want_line.line_valid)
          note_mismatch("line_valid", want_line.line_valid, seen_line.line_valid);
        if (seen_line.pc_mode !== want_line.pc_mode)
          note_mismatch("pc_mode", want_line.pc_mode, seen_line.pc_mode);
        if (seen_line.status_accepted !== want_line.status_accepted)
          note_mismatch("status_accepted", want_line.status_accepted,
                        seen_line.status_accepted);
        if (seen_line.update_needed !== want_line.update_needed)
          note_mismatch("update_needed", want_line.update_needed,
                        seen_line.update_needed);
        if (seen_line.peer_band !== want_line.peer_band)
          note_mismatch("peer_band", want_line.peer_band, seen_line.peer_band);
        if (seen_line.peer_antenna !== want_line.peer_antenna)
          note_mismatch("peer_antenna", want_line.peer_antenna,
                        seen_line.peer_antenna);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sending
  // --------------------------------------------------------------------------
  task automatic send_item(input item_kind_t k, input logic [7:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= k;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_taken);
    n_items++;
    if (k == KIND_TIMEOUT) n_timeouts++;
    predict_item(k, b);
  endtask

  // sends the assembled line; an odd link timeout lands mid-line
  task automatic send_line();
    foreach (line_buf[i]) begin
      if ($urandom_range(49) == 0) send_item(KIND_TIMEOUT, 8'($urandom));
      send_item(KIND_BYTE, line_buf[i]);
    end
    line_buf.delete();
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    send_line();
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input int case_mode);
    logic lower;
    lower = (case_mode == CASE_MIXED) ? 1'($urandom_range(1)) : (case_mode == CASE_LOWER);
    if (n < 4'd10) return 8'h30 + n;
    return (lower ? 8'h61 : 8'h41) + n - 8'd10;
  endfunction

  function automatic logic [7:0] any_but_newline();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == CHR_NL) b = 8'h0B;
    return b;
  endfunction

  // "DS" + two band digits + four antenna digits + newline
  task automatic add_status(input logic [7:0] band, input logic [15:0] ant,
                            input int case_mode);
    line_buf.push_back(CHR_DEV);
    line_buf.push_back(CHR_STAT);
    line_buf.push_back(hex_char(band[7:4], case_mode));
    line_buf.push_back(hex_char(band[3:0], case_mode));
    for (int i = 3; i >= 0; i--) line_buf.push_back(hex_char(ant[4*i +: 4], case_mode));
    line_buf.push_back(CHR_NL);
  endtask

  // Hold the sender until all results are in, then let the pipeline empty
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One APB transfer: setup, access, then back to idle
  task automatic apb_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    rdata = cfg_prdata;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_band_limit(input logic [7:0] v);
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] rd;
    addr = CFG_ADDR_W'(4 * int'(REG_BAND_LIMIT));
    drain_results();
    apb_access(1'b1, addr, CFG_DATA_W'(v), rd);
    band_limit_m = v;
    apb_access(1'b0, addr, '0, rd);
    if (rd[7:0] !== v) note_mismatch("band_limit readback", v, rd[7:0]);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Framing and classification corner cases at the reset band limit
  task automatic test_directed_lines();
    send_text("\n");                              // empty line
    send_text("D\n");                             // one character only
    add_status(8'h0A, 16'h1234, CASE_UPPER);      // at limit, link was down
    send_line();
    add_status(8'h0A, 16'h1234, CASE_UPPER);      // repeat, no update
    send_line();
    add_status(8'h0B, 16'h1234, CASE_UPPER);      // band above limit
    send_line();
    add_status(8'h05, 16'hBEEF, CASE_LOWER);      // lower-case digits
    send_line();
    send_text("DS0G1234\n");                      // bad hex digit
    send_text("DS0A12345\n");                     // one digit too many
    send_text("DS0A123\n");                       // one digit short
    send_text("PX\n");                            // PC line
    send_text("P\n");                             // short PC line
    send_text("Dq\n");                            // other device line
    send_text("XY\n");                            // unknown sender
    send_text("ds0a1234\n");                      // lower-case sender
    line_buf.push_back(8'hFF);
    line_buf.push_back(8'h80);
    line_buf.push_back(CHR_NL);
    send_line();
    send_item(KIND_TIMEOUT, 8'hFF);               // link drops
    add_status(8'h05, 16'hBEEF, CASE_UPPER);      // same values, update again
    send_line();
    send_text("DS");                              // zero byte ends the text
    line_buf.push_back(CHR_NUL);
    send_text("0A1234\n");
    send_text("D");
    line_buf.push_back(CHR_NUL);
    send_text("S\n");
    send_text("DS0A");                            // timeout inside a line
    send_item(KIND_TIMEOUT, 8'h00);
    send_text("1234\n");
    repeat (BUF_SIZE) line_buf.push_back("x");    // overflow, line dropped
    send_line();
    add_status(8'h00, 16'h0000, CASE_UPPER);
    send_line();
    line_buf.push_back(CHR_PC);                   // newline in the last slot
    repeat (BUF_SIZE - 2) line_buf.push_back("y");
    line_buf.push_back(CHR_NL);
    send_line();
  endtask

  // Band limit at both ends of its range
  task automatic test_band_limit_extremes();
    set_band_limit(8'd0);
    add_status(8'h00, 16'hFFFF, CASE_UPPER);
    send_line();
    add_status(8'h01, 16'h0000, CASE_LOWER);
    send_line();
    set_band_limit(8'd255);
    add_status(8'hFF, 16'h0000, CASE_MIXED);
    send_line();
    add_status(8'hFF, 16'h0000, CASE_MIXED);
    send_line();
    send_item(KIND_TIMEOUT, 8'h5A);
    add_status(8'hFF, 16'h0000, CASE_UPPER);
    send_line();
    set_band_limit(BAND_LIMIT_RST);
  endtask

  // Mostly well-formed status lines, the rest PC, other, noise, overflow and link timeouts
  task automatic send_random_line();
    int         r;
    int         pos;
    logic [7:0] band;
    logic [15:0] ant;
    r = $urandom_range(99);
    if (r < 55 || (r >= 72 && r < 80)) begin
      case ($urandom_range(3))
        0:       band = 8'($urandom_range(band_limit_m));
        1:       band = band_limit_m + 8'($urandom_range(1));
        2:       band = stored_band_m;
        default: band = 8'($urandom);
      endcase
      ant = ($urandom_range(2) == 0) ? stored_ant_m : 16'($urandom);
      add_status(band, ant, CASE_MIXED);
      if (r >= 72) begin
        line_buf[$urandom_range(7, 1)] = CHR_NUL;
      end else if ($urandom_range(9) == 0) begin
        line_buf[$urandom_range(7, 2)] = 8'($urandom);
      end else if ($urandom_range(9) == 0) begin
        pos = $urandom_range(7, 2);
        if ($urandom_range(1)) line_buf.delete(pos);
        else line_buf.insert(pos, hex_char(4'($urandom), CASE_MIXED));
      end
    end else if (r < 65) begin
      line_buf.push_back(CHR_PC);
      repeat ($urandom_range(9)) line_buf.push_back(any_but_newline());
      line_buf.push_back(CHR_NL);
    end else if (r < 72) begin
      line_buf.push_back(CHR_DEV);
      repeat ($urandom_range(9)) line_buf.push_back(any_but_newline());
      line_buf.push_back(CHR_NL);
    end else if (r < 88) begin
      repeat ($urandom_range(12)) line_buf.push_back(8'($urandom));
      line_buf.push_back(CHR_NL);
    end else if (r < 94) begin
      repeat (BUF_SIZE + $urandom_range(12)) line_buf.push_back(any_but_newline());
    end else begin
      send_item(KIND_TIMEOUT, 8'($urandom));
    end
    send_line();
  endtask

  task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                     input int unsigned n_bytes);
    int unsigned stop_at;
    set_band_limit(8'($urandom));
    in_idle_pct  = sender_pct;
    out_idle_pct = receiver_pct;
    stop_at = n_items + n_bytes;
    while (n_items < stop_at) begin
      send_random_line();
      if ($urandom_range(39) == 0) drain_results();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    in_idle_pct  = 12;
    out_idle_pct = 65;
    test_directed_lines();
    test_band_limit_extremes();
    test_random_traffic(12, 65, 220);
    test_random_traffic(65, 12, 220);
    test_random_traffic(0, 0, 220);
    drain_results();
    repeat (8) @(posedge clk);
    $display("Sent %0d transactions (%0d link timeouts); checked %0d lines,",
             n_items, n_timeouts, n_lines);
    $display("%0d status stores, %0d updates; band limits 0, 10, 255 and random.",
             n_stored, n_updates);
    if (mismatches == 0 && pending_lines.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> files.f
rtl/slr_pkg.sv
rtl/slr_cfg.sv
rtl/slr_line_proc.sv
rtl/status_line_receiver_core.sv
tb/tb_top.sv
